/* rtl/core/path_clip_box_containment_defines.svh */
// Assertion macros shared by the path clip-box containment RTL.
`ifndef PATH_CLIP_BOX_CONTAINMENT_DEFINES_SVH
`define PATH_CLIP_BOX_CONTAINMENT_DEFINES_SVH

// Check a property on aclk, held off while aresetn is low.
`define PCB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on aclk at every edge, reset included.
`define PCB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/core/pcb_pkg.sv */
// Package with types, codes and constants of the path clip-box containment block.
package pcb_pkg;

    localparam int unsigned DEF_MAX_PATH_LEN = 65536;
    localparam int unsigned COORD_W          = 32;
    localparam int unsigned INDEX_W          = 17;
    localparam logic [INDEX_W-1:0] NONE_INDEX = 17'h10000;
    localparam logic [1:0] PENDING_MASK      = 2'h3;

    typedef enum logic [2:0] {
        CMD_MOVE  = 3'd0,
        CMD_LINE  = 3'd1,
        CMD_QUAD  = 3'd2,
        CMD_CUBIC = 3'd3,
        CMD_CLOSE = 3'd4
    } pcb_cmd_t;

    typedef enum logic [1:0] {
        ST_BOUNDED   = 2'd0,
        ST_UNBOUNDED = 2'd1,
        ST_INVALID   = 2'd2
    } pcb_status_t;

    typedef enum logic [1:0] {
        REG_MIN_X = 2'd0,
        REG_MIN_Y = 2'd1,
        REG_MAX_X = 2'd2,
        REG_MAX_Y = 2'd3
    } pcb_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
    } pcb_box_t;

    typedef struct packed {
        logic [2:0]                cmd;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      path_end;
    } pcb_vertex_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [INDEX_W-1:0]        outside_index;
        logic signed [COORD_W-1:0] move_x;
        logic signed [COORD_W-1:0] move_y;
    } pcb_result_t;

endpackage

/* rtl/core/pcb_box_cmp.sv */
// Inclusive point-in-box compare against the configured clip box.
module pcb_box_cmp
    import pcb_pkg::*;
(
    input  pcb_box_t                  box,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    output logic                      in_box
);

    always_comb begin
        in_box = ($signed(point_x) >= $signed(box.min_x)) &&
                 ($signed(point_y) >= $signed(box.min_y)) &&
                 ($signed(point_x) <= $signed(box.max_x)) &&
                 ($signed(point_y) <= $signed(box.max_y));
    end

endmodule

/* rtl/core/pcb_path_ctl.sv */
// Per-path state: command order, curve points, first fault and the result value.
`include "path_clip_box_containment_defines.svh"
module pcb_path_ctl
    import pcb_pkg::*;
#(
    parameter int unsigned MAX_PATH_LEN = DEF_MAX_PATH_LEN
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_en,
    input  pcb_vertex_t vtx,
    input  logic        in_box,
    output pcb_result_t result
);

    localparam logic [31:0] MaxLen = 32'(MAX_PATH_LEN);

    logic               has_initial_reg, has_initial_next;
    logic [1:0]         pending_reg, pending_next;
    logic               decided_reg, decided_next;
    logic [1:0]         verdict_reg, verdict_next;
    logic [INDEX_W-1:0] count_reg, count_next;
    logic [INDEX_W-1:0] seg_start_reg, seg_start_next;
    logic [INDEX_W-1:0] found_reg, found_next;
    logic signed [COORD_W-1:0] move_x_reg, move_x_next;
    logic signed [COORD_W-1:0] move_y_reg, move_y_next;

    logic test;
    logic count_adv;

    assign count_adv = (({15'd0, count_reg} + 32'd1) < MaxLen);

    always_comb begin
        has_initial_next = has_initial_reg;
        pending_next     = pending_reg;
        decided_next     = decided_reg;
        verdict_next     = verdict_reg;
        seg_start_next   = seg_start_reg;
        found_next       = found_reg;
        move_x_next      = move_x_reg;
        move_y_next      = move_y_reg;
        test             = 1'b0;

        if (!decided_reg) begin
            if (pending_reg != 2'd0) begin
                // further control point of a running curve: cmd is ignored
                pending_next = (pending_reg - 2'd1) & PENDING_MASK;
                test         = 1'b1;
            end else begin
                seg_start_next = count_reg;
                unique case (vtx.cmd) inside
                    CMD_MOVE: begin
                        has_initial_next = 1'b1;
                        move_x_next      = vtx.point_x;
                        move_y_next      = vtx.point_y;
                        test             = 1'b1;
                    end
                    CMD_CLOSE: begin
                        has_initial_next = 1'b0;
                    end
                    CMD_LINE, CMD_QUAD, CMD_CUBIC: begin
                        if (has_initial_reg) begin
                            pending_next = (vtx.cmd[1:0] - 2'd1) & PENDING_MASK;
                            test         = 1'b1;
                        end else begin
                            decided_next = 1'b1;
                            verdict_next = ST_INVALID;
                        end
                    end
                    default: begin
                        decided_next = 1'b1;
                        verdict_next = ST_INVALID;
                    end
                endcase
            end
            if (test && !in_box) begin
                decided_next = 1'b1;
                verdict_next = ST_UNBOUNDED;
                found_next   = seg_start_next;
            end
        end

        count_next = count_adv ? (count_reg + 17'd1) : count_reg;

        result.status        = verdict_next;
        result.outside_index = (verdict_next == ST_UNBOUNDED) ? found_next : NONE_INDEX;
        result.move_x        = (verdict_next == ST_BOUNDED) ? '0 : move_x_next;
        result.move_y        = (verdict_next == ST_BOUNDED) ? '0 : move_y_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step_en && vtx.path_end)) begin
            has_initial_reg <= 1'b0;
            pending_reg     <= 2'd0;
            decided_reg     <= 1'b0;
            verdict_reg     <= ST_BOUNDED;
            count_reg       <= '0;
            seg_start_reg   <= '0;
            found_reg       <= NONE_INDEX;
            move_x_reg      <= '0;
            move_y_reg      <= '0;
        end else if (step_en) begin
            has_initial_reg <= has_initial_next;
            pending_reg     <= pending_next;
            decided_reg     <= decided_next;
            verdict_reg     <= verdict_next;
            count_reg       <= count_next;
            seg_start_reg   <= seg_start_next;
            found_reg       <= found_next;
            move_x_reg      <= move_x_next;
            move_y_reg      <= move_y_next;
        end
    end

    `PCB_ASSERT(a_decided_matches_verdict, decided_reg == (verdict_reg != ST_BOUNDED), "decided flag disagrees with verdict")
    `PCB_ASSERT(a_unbounded_has_index, (verdict_reg == ST_UNBOUNDED) |-> (found_reg != NONE_INDEX), "unbounded path without an outside index")
    `PCB_ASSERT(a_curve_needs_start, (pending_reg != 2'd0) |-> has_initial_reg, "curve points pending without an initial point")
    `PCB_ASSERT(a_clear_after_end, (step_en && vtx.path_end) |=> (!decided_reg && count_reg == '0 && pending_reg == 2'd0), "path state not cleared after last vertex")

endmodule

/* rtl/core/pcb_out_stage.sv */
// Result register that holds a finished result until the sink takes it.
module pcb_out_stage
    import pcb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  pcb_result_t load_data,
    input  logic        m_tready,
    output logic        m_tvalid,
    output pcb_result_t data
);

    logic        valid_reg;
    pcb_result_t data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign data     = data_reg;

endmodule

/* rtl/core/path_clip_box_containment.sv */
// Top level of the path clip-box containment checker.
//
//  Channel  | Ports                     | Carries
//  ---------+---------------------------+-------------------------------------------
//  input    | s_tvalid/s_tready/s_tdata | one path vertex: point, cmd in tuser, tlast
//  result   | m_tvalid/m_tready/m_tdata | verdict on the path_end vertex, status tuser
//  config   | psel/penable/pwrite/paddr | clip box bounds, four 32-bit registers
//
//  One vertex per cycle unless a path_end vertex is held: a vertex sits in the input
//  register while the box compare and the path state update run, and the result
//  register takes the verdict; m_tvalid rises as it takes a path_end vertex's verdict.
//  Vertices that carry no path_end keep flowing while a result waits at m_*; only a
//  path_end vertex holds in the input register until the result register is free.
//  Reset (aresetn low, synchronous) clears the path state, the box and both valids.
//  Per-path state clears itself after the path_end vertex.
module path_clip_box_containment
    import pcb_pkg::*;
#(
    parameter int unsigned MAX_PATH_LEN = DEF_MAX_PATH_LEN
)
(
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // vertex requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // point_x [31:0], point_y [63:32]
    input  logic [2:0]  s_tuser,   // cmd [2:0]
    input  logic        s_tlast,   // path_end
    // result requests
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // outside_index [16:0], move_x [48:17], move_y [80:49]
    output logic [1:0]  m_tuser    // status [1:0]
);

    pcb_box_t    box_reg;
    logic        in_valid_reg;
    pcb_vertex_t in_reg;
    logic        advance;
    logic        in_box;
    logic        cfg_write;
    pcb_result_t result;
    pcb_result_t out_data;

    // Configuration: write on the access cycle, reads straight from the box.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_reg <= '0;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_MIN_X: box_reg.min_x <= pwdata;
                REG_MIN_Y: box_reg.min_y <= pwdata;
                REG_MAX_X: box_reg.max_x <= pwdata;
                REG_MAX_Y: box_reg.max_y <= pwdata;
                default:   box_reg       <= box_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MIN_X: prdata = box_reg.min_x;
            REG_MIN_Y: prdata = box_reg.min_y;
            REG_MAX_X: prdata = box_reg.max_x;
            REG_MAX_Y: prdata = box_reg.max_y;
            default:   prdata = '0;
        endcase
    end

    // Advance the held vertex unless it carries a result and the result register is full.
    assign advance  = in_valid_reg && (!in_reg.path_end || !m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg.cmd      <= s_tuser;
            in_reg.point_x  <= s_tdata[31:0];
            in_reg.point_y  <= s_tdata[63:32];
            in_reg.path_end <= s_tlast;
        end
    end

    pcb_box_cmp u_box_cmp (
        .box     (box_reg),
        .point_x (in_reg.point_x),
        .point_y (in_reg.point_y),
        .in_box  (in_box)
    );

    pcb_path_ctl #(
        .MAX_PATH_LEN (MAX_PATH_LEN)
    ) u_path_ctl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .vtx     (in_reg),
        .in_box  (in_box),
        .result  (result)
    );

    pcb_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && in_reg.path_end),
        .load_data (result),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .data      (out_data)
    );

    assign m_tdata = {7'd0, out_data.move_y, out_data.move_x, out_data.outside_index};
    assign m_tuser = out_data.status;

endmodule

/* bench/tb_path_clip_box_containment.sv */
// Self-checking bench for the path clip-box containment block: random paths, box checks, stalls.
`timescale 1ns / 1ps

module tb_path_clip_box_containment;
    import pcb_pkg::*;

    // Vertex index saturation point, shared by the block and the path tracer.
    localparam int unsigned PATH_LEN_CAP = DEF_MAX_PATH_LEN;
    // Give up well past the slowest legal run.
    localparam int RUN_LIMIT = 200_000;
    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;
    // Command codes the block does not know; each one spoils a path at a command start.
    localparam logic [2:0] CMD_RSVD_A = 3'd5;
    localparam logic [2:0] CMD_RSVD_B = 3'd6;
    localparam logic [2:0] CMD_RSVD_C = 3'd7;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // point_x [31:0], point_y [63:32]
    logic [2:0]  s_tuser = '0;   // cmd [2:0]
    logic        s_tlast = 1'b0; // path_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;        // outside_index [16:0], move_x [48:17], move_y [80:49]
    logic [1:0]  m_tuser;        // status [1:0]

    path_clip_box_containment #(.MAX_PATH_LEN(PATH_LEN_CAP)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    pcb_vertex_t vertex_feed[$];   // vertices waiting for the driver
    pcb_result_t verdict_due[$];   // verdicts owed by the block, oldest first
    int          mismatch_count = 0;
    int          cycle_count = 0;
    logic        feed_on = 1'b0;   // driver held off until reset is over
    logic        vtx_taken = 1'b0; // vertex request accepted at the last rising edge

    // Clip box mirror, written on each register write seen on the bus.
    logic signed [31:0] clip_min_x, clip_min_y, clip_max_x, clip_max_y;

    // Path tracer state: what the block must hold for the path in flight.
    logic               path_has_start;
    logic [1:0]         ctrl_pts_left;
    logic               path_decided;
    pcb_status_t        path_status;
    logic [16:0]        vtx_idx;
    logic [16:0]        seg_first_idx;
    logic [16:0]        hit_idx;
    logic signed [31:0] move_px, move_py;

    // ------------------------------------------------------------------
    // Path tracer
    // ------------------------------------------------------------------
    function automatic bit in_clip_box(logic signed [31:0] x, logic signed [31:0] y);
        return x >= clip_min_x && y >= clip_min_y && x <= clip_max_x && y <= clip_max_y;
    endfunction

    task automatic clear_path_state();
        path_has_start = 1'b0;
        ctrl_pts_left  = 2'd0;
        path_decided   = 1'b0;
        path_status    = ST_BOUNDED;
        vtx_idx        = '0;
        seg_first_idx  = '0;
        hit_idx        = NONE_INDEX;
        move_px        = '0;
        move_py        = '0;
    endtask

    // Advance the path state by one accepted vertex; owe a verdict on the path end.
    task automatic trace_vertex(input logic [2:0] cmd, input logic signed [31:0] x,
                                input logic signed [31:0] y, input logic last);
        logic        probe;
        pcb_result_t owed;
        probe = 1'b0;
        if (!path_decided) begin
            if (ctrl_pts_left != 2'd0) begin
                // further control point of a running curve: cmd is don't-care
                ctrl_pts_left = ctrl_pts_left - 2'd1;
                probe = 1'b1;
            end else begin
                seg_first_idx = vtx_idx;
                case (cmd) inside
                    CMD_MOVE: begin
                        // save before testing, so an outside move reports itself
                        path_has_start = 1'b1;
                        move_px = x;
                        move_py = y;
                        probe = 1'b1;
                    end
                    CMD_CLOSE: begin
                        path_has_start = 1'b0;
                    end
                    CMD_LINE, CMD_QUAD, CMD_CUBIC: begin
                        if (path_has_start) begin
                            ctrl_pts_left = cmd[1:0] - 2'd1;
                            probe = 1'b1;
                        end else begin
                            path_decided = 1'b1;
                            path_status = ST_INVALID;
                        end
                    end
                    default: begin
                        path_decided = 1'b1;
                        path_status = ST_INVALID;
                    end
                endcase
            end
            if (probe && !in_clip_box(x, y)) begin
                path_decided = 1'b1;
                path_status = ST_UNBOUNDED;
                hit_idx = seg_first_idx;
            end
        end
        // saturate the index just below the path length cap
        if (int'(vtx_idx) + 1 < PATH_LEN_CAP)
            vtx_idx = vtx_idx + 17'd1;
        if (last) begin
            owed.status        = path_status;
            owed.outside_index = (path_status == ST_UNBOUNDED) ? hit_idx : NONE_INDEX;
            owed.move_x        = (path_status == ST_BOUNDED) ? '0 : move_px;
            owed.move_y        = (path_status == ST_BOUNDED) ? '0 : move_py;
            verdict_due.push_back(owed);
            clear_path_state();
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample both channels and the config bus at the rising edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        pcb_result_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        if (!aresetn) begin
            clear_path_state();
            clip_min_x = '0;
            clip_min_y = '0;
            clip_max_x = '0;
            clip_max_y = '0;
            vtx_taken <= 1'b0;
        end else begin
            // mirror register writes into the tracer's box
            if (psel && penable && pwrite && pready) begin
                case (pcb_reg_t'(paddr[3:2]))
                    REG_MIN_X: clip_min_x = pwdata;
                    REG_MIN_Y: clip_min_y = pwdata;
                    REG_MAX_X: clip_max_x = pwdata;
                    REG_MAX_Y: clip_max_y = pwdata;
                    default: ;
                endcase
            end
            // trace from what actually sits on the bus, not from the queue
            vtx_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                trace_vertex(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tlast);
            if (m_tvalid && m_tready) begin
                if (verdict_due.size() == 0) begin
                    $error("verdict request with none owed: status %0d index %0d",
                           m_tuser, m_tdata[16:0]);
                    mismatch_count++;
                end else begin
                    want = verdict_due.pop_front();
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        mismatch_count++;
                    end
                    if (m_tdata[16:0] !== want.outside_index) begin
                        $error("outside_index: expected %0d, got %0d",
                               want.outside_index, m_tdata[16:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[48:17] !== want.move_x) begin
                        $error("move_x: expected %0d, got %0d",
                               want.move_x, $signed(m_tdata[48:17]));
                        mismatch_count++;
                    end
                    if (m_tdata[80:49] !== want.move_y) begin
                        $error("move_y: expected %0d, got %0d",
                               want.move_y, $signed(m_tdata[80:49]));
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: offer vertices in bursts, change inputs at the falling edge
    // ------------------------------------------------------------------
    int          burst_left = 0;
    int          gap_left = 0;
    pcb_vertex_t next_vtx;

    always @(negedge aclk) begin
        if (!feed_on) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !vtx_taken) begin
            // hold the request until the block takes it
        end else if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            s_tvalid <= 1'b0;
        end else if (vertex_feed.size() != 0) begin
            next_vtx = vertex_feed.pop_front();
            s_tdata  <= {next_vtx.point_y, next_vtx.point_x};
            s_tuser  <= next_vtx.cmd;
            s_tlast  <= next_vtx.path_end;
            s_tvalid <= 1'b1;
            if (burst_left <= 1) begin
                // end of burst: pick the next one, and often no gap at all
                burst_left <= $urandom_range(1, 24);
                gap_left   <= ($urandom % 3 == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall on its own pattern, plus a periodic long hold-off
    // ------------------------------------------------------------------
    int rx_cycle = 0;
    int long_hold = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;

    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (long_hold != 0) begin
            long_hold <= long_hold - 1;
            m_tready <= 1'b0;
        end else if (rx_cycle % 1700 == 850) begin
            // hold off long enough for the result register to back up into the input
            long_hold <= 150;
            m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode <= $urandom % 4;
                rx_mode_left <= $urandom_range(16, 200);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom % 2);
                2: m_tready <= ($urandom % 4 == 0);
                default: m_tready <= ($urandom % 8 != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] pick_coord(longint lo, longint hi);
        longint unsigned span, r;
        span = longint'(hi - lo + 1);
        r = {$urandom(), $urandom()};
        return 32'(lo + longint'(r % span));
    endfunction

    function automatic logic signed [31:0] coord_in(logic signed [31:0] lo,
                                                   logic signed [31:0] hi);
        int r;
        r = $urandom % 8;
        if (lo > hi)
            return pick_coord(COORD_MIN, COORD_MAX);
        if (r == 0)
            return lo;
        if (r == 1)
            return hi;
        return pick_coord(lo, hi);
    endfunction

    function automatic logic signed [31:0] coord_out(logic signed [31:0] lo,
                                                    logic signed [31:0] hi);
        bit low_side;
        if (lo > hi)
            return pick_coord(COORD_MIN, COORD_MAX);
        if (lo == COORD_MIN && hi == COORD_MAX)
            return pick_coord(lo, hi);
        if (lo == COORD_MIN)
            low_side = 1'b0;
        else if (hi == COORD_MAX)
            low_side = 1'b1;
        else
            low_side = $urandom % 2;
        // just past the edge now and then, to probe the inclusive bounds
        if (low_side)
            return ($urandom % 4 == 0) ? lo - 1 : pick_coord(COORD_MIN, longint'(lo) - 1);
        return ($urandom % 4 == 0) ? hi + 1 : pick_coord(longint'(hi) + 1, COORD_MAX);
    endfunction

    task automatic push_vtx(input logic [2:0] cmd, input logic signed [31:0] x,
                            input logic signed [31:0] y, input logic last);
        pcb_vertex_t v;
        v.cmd = cmd;
        v.point_x = x;
        v.point_y = y;
        v.path_end = last;
        vertex_feed.push_back(v);
    endtask

    // Wait for the block to go quiet: nothing queued, nothing offered, nothing owed.
    task automatic settle();
        while (vertex_feed.size() != 0 || s_tvalid || verdict_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_access(input pcb_reg_t idx, input logic wr, input logic [31:0] wdata);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= wr;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (!wr && prdata !== wdata) begin
            $error("register %0d readback: expected %h, got %h", idx, wdata, prdata);
            mismatch_count++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drain, load a new clip box, and read every bound back.
    task automatic load_box(input logic signed [31:0] lx, input logic signed [31:0] ly,
                            input logic signed [31:0] hx, input logic signed [31:0] hy);
        settle();
        apb_access(REG_MIN_X, 1'b1, lx);
        apb_access(REG_MIN_Y, 1'b1, ly);
        apb_access(REG_MAX_X, 1'b1, hx);
        apb_access(REG_MAX_Y, 1'b1, hy);
        apb_access(REG_MIN_X, 1'b0, lx);
        apb_access(REG_MIN_Y, 1'b0, ly);
        apb_access(REG_MAX_X, 1'b0, hx);
        apb_access(REG_MAX_Y, 1'b0, hy);
    endtask

    // Mostly inside the box; once in a while push x, y or both out.
    task automatic pick_point(output logic signed [31:0] x, output logic signed [31:0] y);
        int r;
        r = $urandom % 40;
        x = (r == 0 || r == 2) ? coord_out(clip_min_x, clip_max_x)
                               : coord_in(clip_min_x, clip_max_x);
        y = (r == 1 || r == 2) ? coord_out(clip_min_y, clip_max_y)
                               : coord_in(clip_min_y, clip_max_y);
    endtask

    // Build one path and queue it. Most paths are well formed; the rest are
    // noise, paths with no leading move, or paths cut inside a curve.
    task automatic gen_path(output int n_items);
        int                 kind, n_cmds, r, n_pts, cut;
        logic [2:0]         c;
        logic signed [31:0] x, y;
        pcb_vertex_t        v;
        pcb_vertex_t        path[$];
        kind = $urandom % 16;
        n_cmds = $urandom_range(1, 10);
        for (int i = 0; i <= n_cmds; i++) begin
            if (i == n_cmds) begin
                // a cut path closes on an open curve; the others stop here
                if (kind != 2)
                    break;
                c = ($urandom % 2) ? CMD_QUAD : CMD_CUBIC;
            end else if (kind == 0) begin
                c = 3'($urandom % 8);
            end else if (i == 0) begin
                c = (kind == 1) ? 3'($urandom_range(CMD_LINE, CMD_RSVD_C)) : CMD_MOVE;
            end else begin
                r = $urandom % 100;
                if (r < 28)      c = CMD_LINE;
                else if (r < 48) c = CMD_QUAD;
                else if (r < 68) c = CMD_CUBIC;
                else if (r < 80) c = CMD_MOVE;
                else if (r < 95) c = CMD_CLOSE;
                else             c = 3'($urandom_range(CMD_RSVD_A, CMD_RSVD_C));
            end
            n_pts = (c == CMD_QUAD) ? 2 : (c == CMD_CUBIC) ? 3 : 1;
            for (int j = 0; j < n_pts; j++) begin
                // control points carry a random, ignored command
                v.cmd = (j == 0) ? c : 3'($urandom % 8);
                if (kind == 0 || c == CMD_CLOSE) begin
                    x = pick_coord(COORD_MIN, COORD_MAX);
                    y = pick_coord(COORD_MIN, COORD_MAX);
                end else begin
                    pick_point(x, y);
                end
                v.point_x = x;
                v.point_y = y;
                v.path_end = 1'b0;
                path.push_back(v);
            end
            if (i == n_cmds) begin
                cut = $urandom_range(1, n_pts - 1);
                repeat (cut) void'(path.pop_back());
            end
        end
        path[path.size() - 1].path_end = 1'b1;
        n_items = path.size();
        foreach (path[k])
            vertex_feed.push_back(path[k]);
    endtask

    task automatic run_random(input int target);
        int n, fed, paths;
        fed = 0;
        paths = 0;
        while (fed < target) begin
            gen_path(n);
            fed += n;
            paths++;
            // now and then pause the sender until every verdict is in
            if (paths % 60 == 0)
                settle();
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    logic signed [31:0] ra, rb, rc, rd;

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        feed_on <= 1'b1;

        // Directed paths against a box of +-100.0 by +-50.0
        load_box(-32'sd25600, -32'sd12800, 32'sd25600, 32'sd12800);
        // every command kind, curve points with junk commands, untested close point
        push_vtx(CMD_MOVE, 32'sd100, 32'sd100, 1'b0);
        push_vtx(CMD_LINE, -32'sd200, 32'sd300, 1'b0);
        push_vtx(CMD_QUAD, 32'sd0, 32'sd0, 1'b0);
        push_vtx(CMD_CLOSE, 32'sd25600, 32'sd12800, 1'b0);
        push_vtx(CMD_CUBIC, 32'sd1, 32'sd1, 1'b0);
        push_vtx(CMD_RSVD_C, -32'sd25600, -32'sd12800, 1'b0);
        push_vtx(CMD_MOVE, 32'sd5, 32'sd5, 1'b0);
        push_vtx(CMD_CLOSE, COORD_MAX, COORD_MIN, 1'b1);
        // both corners exactly on the bounds
        push_vtx(CMD_MOVE, 32'sd25600, 32'sd12800, 1'b0);
        push_vtx(CMD_LINE, -32'sd25600, -32'sd12800, 1'b1);
        // line with no start point
        push_vtx(CMD_LINE, 32'sd0, 32'sd0, 1'b1);
        // move just outside reports itself
        push_vtx(CMD_MOVE, 32'sd25601, 32'sd0, 1'b1);
        // second quad point outside, then an ignored vertex
        push_vtx(CMD_MOVE, 32'sd10, -32'sd10, 1'b0);
        push_vtx(CMD_QUAD, 32'sd20, 32'sd20, 1'b0);
        push_vtx(CMD_LINE, 32'sd0, -32'sd12801, 1'b0);
        push_vtx(CMD_RSVD_C, 32'sd0, 32'sd0, 1'b1);
        // unknown command after a move
        push_vtx(CMD_MOVE, -32'sd5, 32'sd7, 1'b0);
        push_vtx(CMD_RSVD_A, 32'sd0, 32'sd0, 1'b1);
        // path ends inside a cubic
        push_vtx(CMD_MOVE, 32'sd0, 32'sd0, 1'b0);
        push_vtx(CMD_CUBIC, 32'sd1, 32'sd2, 1'b0);
        push_vtx(CMD_RSVD_B, 32'sd3, 32'sd4, 1'b1);
        // extreme coordinates
        push_vtx(CMD_MOVE, COORD_MIN, COORD_MAX, 1'b1);

        // Random paths over a range of boxes
        load_box(-32'sd256000, -32'sd153600, 32'sd256000, 32'sd153600);
        run_random(400);
        // full range: nothing can fall outside
        load_box(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        run_random(300);
        // empty box: min above max on both axes
        load_box(COORD_MAX, 32'sd2560, COORD_MIN, -32'sd2560);
        run_random(150);
        // box of a single point
        load_box(32'sd777, -32'sd333, 32'sd777, -32'sd333);
        run_random(150);
        repeat (3) begin
            ra = pick_coord(COORD_MIN, COORD_MAX);
            rb = pick_coord(COORD_MIN, COORD_MAX);
            rc = pick_coord(COORD_MIN, COORD_MAX);
            rd = pick_coord(COORD_MIN, COORD_MAX);
            load_box((ra < rb) ? ra : rb, (rc < rd) ? rc : rd,
                     (ra < rb) ? rb : ra, (rc < rd) ? rd : rc);
            run_random(250);
        end

        settle();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
